// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_NULL  = 3'd1;
   localparam logic [2:0] ST_DUP   = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   // One held entry.
   typedef struct packed {
      logic [31:0]        handle;
      logic [7:0]         kind;
      logic signed [31:0] prio;
   } entry_type;

   // Operation broadcast to every cell in the cycle of a transfer.
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type fresh;
   } cell_cmd_type;

endpackage

// ===== src/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue, lowest priority value first, FIFO among equals.
// ----------------------------------------------------------------------------
//
//   channel | direction | tdata (low bit up)                 | tuser (low bit up)
//   --------+-----------+------------------------------------+----------------------
//   req     | in        | item_handle[31:0] priority_req[63:32] | command[0] kind[8:1]
//   rsp     | out       | out_handle[31:0] out_priority[63:32]  | status[2:0]
//           |           | held_count[70:64], zero fill          | out_kind[10:3]
//
// Every request transfer produces exactly one response transfer. The entries sit
// in a row of cells, one per slot, that all compare against the new entry in the
// same cycle and shift by one place, so a request is taken in every cycle while
// the response side drains; the response is registered and appears in the cycle
// after the request transfer. A request is taken while the response register is
// empty or being drained, so a stalled response stalls the request side only by
// that one register. Reset clears the fill count and the response valid; slot
// contents are not reset and only slots below the fill count are ever read.
//
module stable_priority_queue_top #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // item_handle[31:0], priority_req[63:32]
   input  logic [8:0]  req_tuser,   // command[0], kind[8:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_handle[31:0], out_priority[63:32],
                                    // held_count[70:64], zero [71]
   output logic [10:0] rsp_tuser    // status[2:0], out_kind[10:3]
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   // Fill count and response register.
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [2:0]    status_ff;
   logic [2:0]    status_in;
   spq_pkg::entry_type out_ff;
   spq_pkg::entry_type out_in;
   logic [6:0]    held_ff;
   logic [6:0]    held_in;

   logic                  req_xfer;
   logic                  is_remove;
   logic                  dup;
   logic                  full;
   logic                  empty;
   spq_pkg::entry_type    fresh;
   spq_pkg::cell_cmd_type cmd;
   spq_pkg::entry_type    ent   [CAPACITY];
   logic [CAPACITY-1:0]   take;
   logic [CAPACITY-1:0]   match;
   logic [CW+6:0]         count_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign is_remove  = (req_tuser[0] == spq_pkg::CMD_REMOVE);

   assign fresh.handle = req_tdata[31:0];
   assign fresh.prio   = req_tdata[63:32];
   assign fresh.kind   = req_tuser[8:1];

   assign dup   = |match;
   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);

   // Decide the outcome; the cells only move on a successful operation.
   always_comb begin
      status_in = spq_pkg::ST_OK;
      out_in    = '0;
      cmd.fresh = fresh;
      cmd.ins   = 1'b0;
      cmd.rem   = 1'b0;
      count_in  = count_ff;
      if (!is_remove) begin
         if (fresh.handle == '0) begin
            status_in = spq_pkg::ST_NULL;
         end else if (dup) begin
            status_in = spq_pkg::ST_DUP;
         end else if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            cmd.ins  = req_xfer;
            count_in = req_xfer ? count_ff + 1'b1 : count_ff;
         end
      end else if (empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end else begin
         out_in   = ent[0];
         cmd.rem  = req_xfer;
         count_in = req_xfer ? count_ff - 1'b1 : count_ff;
      end
   end

   // The count is reported modulo 128.
   assign count_wide   = {7'd0, count_in};
   assign held_in      = count_wide[6:0];
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_tready);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         spq_pkg::entry_type left_e;
         spq_pkg::entry_type right_e;
         logic               left_t;
         if (gi == 0) begin : g_first
            assign left_e = fresh;
            assign left_t = 1'b0;
         end else begin : g_mid
            assign left_e = ent[gi-1];
            assign left_t = take[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_e = ent[gi];
         end else begin : g_inner
            assign right_e = ent[gi+1];
         end
         spq_cell #(
            .CW  (CW),
            .IDX (gi)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .count       (count_ff),
            .left_entry  (left_e),
            .left_take   (left_t),
            .right_entry (right_e),
            .entry       (ent[gi]),
            .take        (take[gi]),
            .match       (match[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         held_ff   <= held_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, held_ff, out_ff.prio, out_ff.handle};
   assign rsp_tuser  = {out_ff.kind, status_ff};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count exceeds capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("request transfer without response");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      req_xfer && is_remove && !empty |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not lower the fill count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> $signed(ent[0].prio) <= $signed(ent[1].prio))
      else $error("head entries out of order");
`endif

endmodule

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares, shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic [CW-1:0]        count,
   input  spq_pkg::entry_type   left_entry,
   input  logic                 left_take,
   input  spq_pkg::entry_type   right_entry,
   output spq_pkg::entry_type   entry,
   output logic                 take,
   output logic                 match
);

   localparam logic [CW-1:0] SLOT = CW'(IDX);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               held;
   logic               greater;

   // Slots below the fill count hold data; the rest are don't-care.
   assign held    = (count > SLOT);
   assign greater = held && ($signed(entry_ff.prio) > $signed(cmd.fresh.prio));
   assign take    = !held || greater;
   assign match   = held && (entry_ff == cmd.fresh);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && take) begin
         entry_in = left_take ? left_entry : cmd.fresh;
      end else if (cmd.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stable priority queue.
// ----------------------------------------------------------------------------
//
// The bench keeps a shadow copy of the queue contents as an ordered list of
// entries and works out the response for each request at the moment its
// transfer is taken. The predicted responses wait in a FIFO. A separate
// checker pops the oldest one for every response transfer and compares it
// field by field.
//
// The run goes through these tests in turn:
//   - removes and null inserts on an empty queue,
//   - priority extremes, FIFO order among equal priorities and duplicates,
//   - filling the queue to capacity, the rejects on a full queue, and
//     draining it past empty,
//   - a long response hold-off while requests keep coming,
//   - random traffic that swings the fill level between empty and full.
//
// All inputs change on the falling clock edge. All outputs are sampled on the
// rising edge.
//
module tb_top;

   localparam int CAPACITY       = spq_pkg::CAPACITY_DEFAULT;
   localparam int RESET_CYCLES   = 12;
   // The response is registered. Waiting on past the last expected response
   // gives a stray response the chance to show up.
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_OFF_LEN   = 200;
   // The longest legal quiet stretch is the hold-off. This limit is many times
   // that.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1050;

   // One response, unpacked into its fields.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] handle;
      logic [7:0]  kind;
      logic [31:0] prio;
      logic [6:0]  count;
   } outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // item_handle[31:0], priority_req[63:32]
   logic [8:0]  req_tuser  = '0;   // command[0], kind[8:1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // out_handle[31:0], out_priority[63:32],
                                   // held_count[70:64], zero [71]
   logic [10:0] rsp_tuser;         // status[2:0], out_kind[10:3]

   // Shadow of the queue contents, with the head at index 0.
   spq_pkg::entry_type shadow_entries[$];
   // Predicted responses that have not been seen yet, oldest first.
   outcome_type pending_outcomes[$];
   outcome_type oldest_outcome;

   int mismatches   = 0;
   int quiet_cycles = 0;

   // Controls for the receiver. max_stall of zero means always ready.
   // hold_left asks for a hold-off, and the receiver counts it down itself.
   int max_stall    = 0;
   int hold_left    = 0;
   int run_left     = 0;
   bit stalling     = 1'b0;

   stable_priority_queue_top #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow queue. This applies one request and returns the response it must
   // produce.
   // ------------------------------------------------------------------------
   task automatic update_shadow_queue(input logic cmd, input logic [31:0] handle,
                                      input logic [7:0] kind,
                                      input logic signed [31:0] prio,
                                      output outcome_type result);
      spq_pkg::entry_type fresh;
      spq_pkg::entry_type taken;
      bit        duplicate;
      int        slot;
      result    = '0;
      fresh     = '{handle: handle, kind: kind, prio: prio};
      duplicate = 1'b0;
      if (cmd == spq_pkg::CMD_REMOVE) begin
         if (shadow_entries.size() == 0) begin
            result.status = spq_pkg::ST_EMPTY;
         end else begin
            taken         = shadow_entries.pop_front();
            result.status = spq_pkg::ST_OK;
            result.handle = taken.handle;
            result.kind   = taken.kind;
            result.prio   = taken.prio;
         end
      end else if (handle == '0) begin
         result.status = spq_pkg::ST_NULL;
      end else begin
         // The duplicate check comes before the full check, so a duplicate
         // on a full queue still reports as a duplicate.
         foreach (shadow_entries[i]) begin
            if (shadow_entries[i] == fresh) duplicate = 1'b1;
         end
         if (duplicate) begin
            result.status = spq_pkg::ST_DUP;
         end else if (shadow_entries.size() >= CAPACITY) begin
            result.status = spq_pkg::ST_FULL;
         end else begin
            // The new entry goes after every entry of equal or lower priority.
            // This keeps equal priorities in arrival order.
            slot = 0;
            while (slot < shadow_entries.size() &&
                   $signed(shadow_entries[slot].prio) <= prio)
               slot++;
            shadow_entries.insert(slot, fresh);
            result.status = spq_pkg::ST_OK;
         end
      end
      result.count = 7'(shadow_entries.size());
   endtask

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // This offers one request and holds it until the transfer happens. Valid
   // stays high on return, so the next call continues the burst without a
   // bubble.
   task automatic send_request(input logic cmd, input logic [31:0] handle,
                               input logic [7:0] kind, input logic signed [31:0] prio);
      outcome_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, handle};
      req_tuser  <= {kind, cmd};
      do @(posedge clock); while (!req_tready);
      update_shadow_queue(cmd, handle, kind, prio, predicted);
      pending_outcomes.push_back(predicted);
   endtask

   // This drops valid for some cycles. The data lines carry junk meanwhile,
   // and the block must ignore it.
   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         req_tuser  <= 9'($urandom);
      end
   endtask

   // The sender pauses until every predicted response has been seen.
   task automatic wait_for_drain;
      idle_sender(1);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // This builds one random request. Most inserts carry fresh entries, and over
   // half of those take priorities from a narrow band, so equal priorities come
   // up often. The rest are null handles, exact copies of held entries, and near
   // copies that differ in one field.
   task automatic random_request(input int insert_pct, output logic cmd,
                                 output logic [31:0] handle, output logic [7:0] kind,
                                 output logic signed [31:0] prio);
      spq_pkg::entry_type held;
      int        pick;
      cmd    = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                     : spq_pkg::CMD_REMOVE;
      handle = $urandom;
      kind   = 8'($urandom);
      prio   = $urandom;
      if (cmd == spq_pkg::CMD_INSERT) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            handle = '0;
         end else if (pick < 10 && shadow_entries.size() != 0) begin
            held = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
            {handle, kind, prio} = held;
            case (pick)
               7:       prio   = prio + 32'sd1;
               8:       kind   = kind ^ 8'h01;
               9:       handle = handle ^ 32'h1;
               default: ;
            endcase
         end else begin
            if (handle == '0) handle = 32'h1;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               prio = $urandom_range(0, 6);
               prio = prio - 32'sd3;
            end else if (pick < 65) begin
               case ($urandom_range(0, 3))
                  0:       prio = 32'h8000_0000;
                  1:       prio = 32'h7FFF_FFFF;
                  2:       prio = 32'h0;
                  default: prio = 32'hFFFF_FFFF;
               endcase
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side.
   // ------------------------------------------------------------------------

   // The receiver alternates runs of ready and runs of stall. No stall run is
   // longer than max_stall. A hold-off request overrides this.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left   = hold_left - 1;
      end else if (max_stall == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            stalling = !stalling;
            run_left = stalling ? $urandom_range(1, max_stall) : $urandom_range(1, 8);
         end
         run_left    = run_left - 1;
         rsp_tready <= !stalling;
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Every response transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transfer with no request outstanding");
            mismatches++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            compare_field("status",       32'(oldest_outcome.status), 32'(rsp_tuser[2:0]));
            compare_field("out_kind",     32'(oldest_outcome.kind),   32'(rsp_tuser[10:3]));
            compare_field("out_handle",   oldest_outcome.handle,      rsp_tdata[31:0]);
            compare_field("out_priority", oldest_outcome.prio,        rsp_tdata[63:32]);
            compare_field("held_count",   32'(oldest_outcome.count),  32'(rsp_tdata[70:64]));
            compare_field("zero fill",    32'h0,                      32'(rsp_tdata[71]));
         end
      end
   end

   // The watchdog ends the run if no transfer happens on either side for too
   // long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // A remove on the empty queue must report empty with zero entry fields.
   // This holds even when the ignored request fields are all ones. A null
   // handle is rejected.
   task automatic test_empty_and_null;
      max_stall = 0;
      send_request(spq_pkg::CMD_REMOVE, '1, '1, '1);
      send_request(spq_pkg::CMD_INSERT, 32'h0, 8'hFF, 32'h7FFF_FFFF);
      wait_for_drain;
   endtask

   // This covers the extremes of every field, FIFO order among equal
   // priorities, exact duplicates, and near duplicates that must be accepted.
   // Then it removes everything and one more.
   task automatic test_order_and_duplicates;
      max_stall = 3;
      send_request(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0001, 8'h00, 32'h8000_0000);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, 8'h01, 32'h0);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0003, 8'h02, 32'h0);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, 8'h01, 32'h0);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, 8'h02, 32'h0);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, 8'h01, 32'hFFFF_FFFF);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0004, 8'h03, 32'hFFFF_FFFF);
      send_request(spq_pkg::CMD_INSERT, 32'h0000_0005, 8'h04, 32'h7FFF_FFFF);
      idle_sender(2);
      repeat (9) send_request(spq_pkg::CMD_REMOVE, $urandom, 8'($urandom), $urandom);
      wait_for_drain;
   endtask

   // This fills the queue to capacity. On a full queue, a null insert still
   // reports null and a copy of a held entry still reports duplicate. Only a
   // fresh entry reports full. Then the queue is drained one step past empty.
   task automatic test_full_queue;
      spq_pkg::entry_type held;
      logic signed [31:0] prio;
      max_stall = 6;
      repeat (CAPACITY) begin
         prio = $urandom_range(0, 4);
         send_request(spq_pkg::CMD_INSERT, $urandom_range(1, 32'hFFFF_FFFF),
                      8'($urandom), prio - 32'sd2);
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
      end
      send_request(spq_pkg::CMD_INSERT, 32'h0, 8'($urandom), $urandom);
      held = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      send_request(spq_pkg::CMD_INSERT, held.handle, held.kind, held.prio);
      send_request(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'h8000_0000);
      repeat (CAPACITY + 1) begin
         send_request(spq_pkg::CMD_REMOVE, $urandom, 8'($urandom), $urandom);
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
      end
      wait_for_drain;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering requests back to back. The block must stall its input and lose
   // nothing.
   task automatic test_hold_off;
      max_stall = 0;
      hold_left = HOLD_OFF_LEN;
      repeat (16) begin
         send_request($urandom_range(0, 3) == 0 ? spq_pkg::CMD_REMOVE : spq_pkg::CMD_INSERT,
                      $urandom, 8'($urandom), $urandom);
      end
      wait_for_drain;
   endtask

   // Random traffic runs in phases of about a hundred requests. The phases
   // alternate between mostly inserts and mostly removes, so the fill level
   // sweeps between full and nearly empty. Every third phase runs with the
   // receiver always ready. Every fourth phase runs without sender gaps.
   task automatic test_random_traffic(input int total);
      int   sent;
      int   phase;
      int   burst;
      int   insert_pct;
      logic cmd;
      logic [31:0] handle;
      logic [7:0]  kind;
      logic signed [31:0] prio;
      sent = 0;
      while (sent < total) begin
         phase      = sent / 100;
         insert_pct = (phase % 2 == 0) ? 90 : 20;
         case (phase % 3)
            0:       max_stall = 0;
            1:       max_stall = 3;
            default: max_stall = 12;
         endcase
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            random_request(insert_pct, cmd, handle, kind, prio);
            send_request(cmd, handle, kind, prio);
            sent++;
         end
         if (phase % 4 != 3) idle_sender($urandom_range(0, 6));
      end
      wait_for_drain;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_null;
      test_order_and_duplicates;
      test_full_queue;
      test_hold_off;
      test_random_traffic(RANDOM_ITEMS);

      wait_for_drain;
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== stable_priority_queue_top.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue_top.sv
tb/sv/tb_top.sv
